>>> sv/fpp_pkg.sv
package fpp_pkg;

    // Output formats selected by the mode register.
    typedef enum logic [1:0] {
        FMT_PCM16  = 2'd0,
        FMT_PCM24  = 2'd1,
        FMT_FLOAT  = 2'd2,
        FMT_SPARE  = 2'd3
    } fmt_t;

    localparam int          MODE_W    = 2;
    localparam int          FLOAT_W   = 32;
    localparam int          MAG_W     = 31;
    localparam int          MANT_W    = 24;
    localparam int          SCALE_W   = 23;
    localparam int          PROD_W    = MANT_W + SCALE_W;
    localparam int          COUNT_W   = 3;

    localparam logic [MAG_W-1:0]   EXP_ALL_ONES = 31'h7F80_0000;
    localparam logic [MAG_W-1:0]   ONE_BITS     = 31'h3F80_0000;
    localparam logic [SCALE_W-1:0] SCALE16      = 23'd32767;
    localparam logic [SCALE_W-1:0] SCALE24      = 23'd8388607;
    localparam logic [7:0]         EXP_ONE      = 8'd127;

    // Word carried from the multiply stage to the rounding stage.
    typedef struct packed {
        logic [PROD_W-1:0]  prod;
        logic [7:0]         expo;
        logic               sign;
        logic               is_nan;
        logic [FLOAT_W-1:0] bits;
        fmt_t               mode;
    } fpp_prod_t;

endpackage

>>> sv/float_to_pcm_peak_meter.sv
// Converts one single-precision sample per cycle while in_stall is low to
// 16-bit or 24-bit PCM (clamped to +/-1.0, scaled, rounded to nearest even,
// truncated toward zero) or passes the float bits through, while tracking
// per-channel peak magnitude and a sticky clip flag. A word is accepted every
// cycle unless the pipeline stalls; the first stage holds the mantissa-times-
// scale product, the second holds the rounded, shifted output. NaN samples give
// zero PCM and leave the meter alone. Write the format register only while idle.
module float_to_pcm_peak_meter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fpp_pkg::MODE_W-1:0]        cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [fpp_pkg::FLOAT_W-1:0]       sample_bits,
    input  logic                              channel,
    input  logic                              block_end,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [fpp_pkg::FLOAT_W-1:0]       pcm_word,
    output logic [fpp_pkg::COUNT_W-1:0]       byte_count,
    output logic [fpp_pkg::MAG_W-1:0]         peak_left_out,
    output logic [fpp_pkg::MAG_W-1:0]         peak_right_out,
    output logic                              clipped,
    output logic                              last_of_block
);

    fpp_pkg::fmt_t                 mode_reg;
    logic [fpp_pkg::MAG_W-1:0]     peak_left_reg, peak_left_next;
    logic [fpp_pkg::MAG_W-1:0]     peak_right_reg, peak_right_next;
    logic                          clip_reg, clip_next;

    logic                          a_valid_reg;
    fpp_pkg::fpp_prod_t            a_prod_reg, a_prod_next;
    logic [fpp_pkg::MAG_W-1:0]     a_pl_reg, a_pr_reg;
    logic                          a_clip_reg, a_last_reg;

    logic                          b_valid_reg;
    logic [fpp_pkg::FLOAT_W-1:0]   b_pcm_reg;
    logic [fpp_pkg::COUNT_W-1:0]   b_count_reg;
    logic [fpp_pkg::MAG_W-1:0]     b_pl_reg, b_pr_reg;
    logic                          b_clip_reg, b_last_reg;

    logic                          b_ready, a_ready, accept;
    logic [fpp_pkg::MAG_W-1:0]     mag;
    logic                          is_nan, over_one;
    logic [fpp_pkg::MANT_W-1:0]    mant;
    logic [fpp_pkg::SCALE_W-1:0]   scale;
    logic [fpp_pkg::FLOAT_W-1:0]   rnd_pcm;
    logic [fpp_pkg::COUNT_W-1:0]   rnd_count;

    // Pipeline flow control.
    assign b_ready  = !b_valid_reg || !out_stall;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_stall = !a_ready;
    assign accept   = in_valid && a_ready;

    // Meter update and clamped multiply for the incoming word.
    always_comb
    begin
        mag      = sample_bits[fpp_pkg::MAG_W-1:0];
        is_nan   = mag > fpp_pkg::EXP_ALL_ONES;
        over_one = mag > fpp_pkg::ONE_BITS;

        peak_left_next  = peak_left_reg;
        peak_right_next = peak_right_reg;
        clip_next       = clip_reg;
        if (!is_nan)
        begin
            if (!channel && mag > peak_left_reg)
            begin
                peak_left_next = mag;
            end
            if (channel && mag > peak_right_reg)
            begin
                peak_right_next = mag;
            end
            if (over_one)
            begin
                clip_next = 1'b1;
            end
        end

        scale = (mode_reg == fpp_pkg::FMT_PCM16) ? fpp_pkg::SCALE16 : fpp_pkg::SCALE24;
        if (over_one)
        begin
            mant             = 24'h80_0000;
            a_prod_next.expo = fpp_pkg::EXP_ONE;
        end
        else
        begin
            mant             = {1'b1, sample_bits[22:0]};
            a_prod_next.expo = sample_bits[30:23];
        end
        a_prod_next.prod   = fpp_pkg::PROD_W'(mant) * fpp_pkg::PROD_W'(scale);
        a_prod_next.sign   = sample_bits[fpp_pkg::FLOAT_W-1];
        a_prod_next.is_nan = is_nan;
        a_prod_next.bits   = sample_bits;
        a_prod_next.mode   = mode_reg;
    end

    // Configuration and meter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= fpp_pkg::FMT_PCM16;
            peak_left_reg  <= '0;
            peak_right_reg <= '0;
            clip_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= fpp_pkg::fmt_t'(cfg_wdata);
            end
            if (accept)
            begin
                peak_left_reg  <= peak_left_next;
                peak_right_reg <= peak_right_next;
                clip_reg       <= clip_next;
            end
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // Product stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_prod_reg <= a_prod_next;
            a_pl_reg   <= peak_left_next;
            a_pr_reg   <= peak_right_next;
            a_clip_reg <= clip_next;
            a_last_reg <= block_end;
        end
    end

    fpp_round u_round (
        .prod_in (a_prod_reg),
        .pcm     (rnd_pcm),
        .count   (rnd_count)
    );

    // Result stage payload.
    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_pcm_reg   <= rnd_pcm;
            b_count_reg <= rnd_count;
            b_pl_reg    <= a_pl_reg;
            b_pr_reg    <= a_pr_reg;
            b_clip_reg  <= a_clip_reg;
            b_last_reg  <= a_last_reg;
        end
    end

    assign out_valid      = b_valid_reg;
    assign pcm_word       = b_pcm_reg;
    assign byte_count     = b_count_reg;
    assign peak_left_out  = b_pl_reg;
    assign peak_right_out = b_pr_reg;
    assign clipped        = b_clip_reg;
    assign last_of_block  = b_last_reg;

    // The clip flag is sticky.
    a_clip_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(clip_reg) |-> clip_reg)
        else $error("clip flag dropped");

    // Peaks never decrease.
    a_peak_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (peak_left_reg >= $past(peak_left_reg)) && (peak_right_reg >= $past(peak_right_reg)))
        else $error("peak decreased");

    // A presented result has a legal byte count.
    a_count_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_count == 3'd2 || byte_count == 3'd3 || byte_count == 3'd4))
        else $error("bad byte count");

    // A word is never taken while the product stage is blocked.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && b_valid_reg && out_stall) |-> !accept)
        else $error("product stage overrun");

endmodule

>>> sv/fpp_round.sv
module fpp_round (
    input  fpp_pkg::fpp_prod_t               prod_in,
    output logic [fpp_pkg::FLOAT_W-1:0]      pcm,
    output logic [fpp_pkg::COUNT_W-1:0]      count
);

    logic                          is16;
    logic                          topset;
    logic [4:0]                    drop;
    logic [fpp_pkg::PROD_W-1:0]    shifted;
    logic [fpp_pkg::PROD_W-1:0]    low_mask;
    logic                          half;
    logic                          sticky;
    logic                          rnd;
    logic [fpp_pkg::MANT_W:0]      rounded;
    logic [8:0]                    rshift;
    logic [fpp_pkg::MANT_W:0]      mag;
    logic [fpp_pkg::FLOAT_W-1:0]   signed_val;

    // Round the exact product to 24 significant bits, nearest even.
    always_comb
    begin
        is16     = (prod_in.mode == fpp_pkg::FMT_PCM16);
        topset   = is16 ? prod_in.prod[38] : prod_in.prod[fpp_pkg::PROD_W-1];
        drop     = (is16 ? 5'd15 : 5'd23) - {4'd0, ~topset};
        shifted  = prod_in.prod >> drop;
        low_mask = (fpp_pkg::PROD_W'(1) << (drop - 5'd1)) - fpp_pkg::PROD_W'(1);
        half     = prod_in.prod[{1'b0, drop - 5'd1}];
        sticky   = |(prod_in.prod & low_mask);
        rnd      = half & (sticky | shifted[0]);
        rounded  = {1'b0, shifted[fpp_pkg::MANT_W-1:0]} + {{fpp_pkg::MANT_W{1'b0}}, rnd};
        rshift   = 9'd150 - {1'b0, prod_in.expo} - {4'd0, drop};
    end

    // Truncate toward zero, apply the sign and pick the format.
    always_comb
    begin
        if (prod_in.expo == 8'd0 || rshift > 9'd24)
        begin
            mag = '0;
        end
        else
        begin
            mag = rounded >> rshift;
        end
        signed_val = {7'd0, mag};
        if (prod_in.sign)
        begin
            signed_val = -signed_val;
        end
        unique case (prod_in.mode)
            fpp_pkg::FMT_PCM16:
            begin
                count = 3'd2;
                pcm   = {16'd0, signed_val[15:0]};
            end
            fpp_pkg::FMT_PCM24:
            begin
                count = 3'd3;
                pcm   = {8'd0, signed_val[23:0]};
            end
            default:
            begin
                count = 3'd4;
                pcm   = prod_in.bits;
            end
        endcase
        if (prod_in.is_nan)
        begin
            pcm = '0;
        end
    end

endmodule
